// File: rtl/urfcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urfcr_pkg
// Shared types and constants for the UART receive buffer and command parser.
// ----------------------------------------------------------------------------
package urfcr_pkg;

  localparam int ByteW    = 8;
  localparam int ErrW     = 3;
  localparam int FillW    = 3;
  localparam int InDataW  = 16;
  localparam int OutDataW = 32;

  localparam logic [ByteW-1:0] CH_O  = 8'h4F;
  localparam logic [ByteW-1:0] CH_K  = 8'h4B;
  localparam logic [ByteW-1:0] CH_CR = 8'h0D;
  localparam logic [ByteW-1:0] CH_E  = 8'h45;
  localparam logic [ByteW-1:0] CH_G  = 8'h47;
  localparam logic [ByteW-1:0] CH_0  = 8'h30;
  localparam logic [ByteW-1:0] CH_1  = 8'h31;

  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [2:0] PS_IDLE  = 3'd0;
  localparam logic [2:0] PS_O     = 3'd1;
  localparam logic [2:0] PS_OK    = 3'd2;
  localparam logic [2:0] PS_E     = 3'd3;
  localparam logic [2:0] PS_EG    = 3'd4;

  typedef logic [InDataW-1:0]  in_data_t;
  typedef logic [OutDataW-1:0] out_data_t;

  typedef struct packed {
    logic             read_valid;
    logic             echo_valid;
    logic [ByteW-1:0] echo_byte;
    logic             ok_seen;
    logic             light_update;
    logic             light_on;
    logic             overflow_flag;
    logic [FillW-1:0] fill_count;
  } stage_t;

endpackage

// File: rtl/urfcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urfcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/uart_rx_fifo_command_recognizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_command_recognizer
// UART receive ring buffer with echo and an O-K-CR / E-G-0/1 command parser.
// ----------------------------------------------------------------------------
// A request's result is held first in the RAM's registered read and the stage
// register, then in the output register.
// Throughput: one request per cycle; a stalled result holds off new requests.
// Reset clears the pointers, byte count, overflow flag, parser state and the
// pipeline valid bits. The RAM contents are not cleared.
// ----------------------------------------------------------------------------
module uart_rx_fifo_command_recognizer #(
  parameter int BUFFER_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [7:0] rx_byte, [10:8] rx_errors, [15:11] zero
  input  urfcr_pkg::in_data_t s_tdata,
  // [0] action
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] read_valid, [8:1] read_byte, [9] echo_valid, [17:10] echo_byte,
  // [18] ok_seen, [19] light_update, [20] light_on, [21] overflow_flag,
  // [24:22] fill_count, [31:25] zero
  output urfcr_pkg::out_data_t m_tdata
);
  import urfcr_pkg::*;

  localparam int PtrW = $clog2(BUFFER_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(BUFFER_DEPTH - 1);

  logic [PtrW-1:0]  write_pointer, write_pointer_next;
  logic [PtrW-1:0]  read_pointer, read_pointer_next;
  logic [PtrW-1:0]  byte_count, byte_count_next;
  logic             overflow_sticky, overflow_sticky_next;
  logic [2:0]       parse_state, parse_state_next;

  logic             s1_valid;
  stage_t           s1, s1_next;
  logic             s1_move;
  logic             accept;
  logic             good_rx;
  logic             do_read;
  logic [ByteW-1:0] rx_byte;
  logic [ErrW-1:0]  rx_errors;
  logic [ByteW-1:0] ram_q;
  logic [PtrW+FillW-1:0] count_ext;
  out_data_t        m_tdata_next;

  assign rx_byte   = s_tdata[ByteW-1:0];
  assign rx_errors = s_tdata[ByteW+ErrW-1:ByteW];
  assign s1_move   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_move;
  assign accept    = s_tvalid && s_tready;
  assign good_rx   = accept && (s_tuser == ACT_RX) && (rx_errors == '0);
  assign do_read   = accept && (s_tuser == ACT_READ) && (byte_count != '0);

  urfcr_ram #(
    .WIDTH(ByteW),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (good_rx),
    .waddr(write_pointer),
    .wdata(rx_byte),
    .re   (accept),
    .raddr(read_pointer),
    .rdata(ram_q)
  );

  always_comb begin
    write_pointer_next   = write_pointer;
    read_pointer_next    = read_pointer;
    byte_count_next      = byte_count;
    overflow_sticky_next = overflow_sticky;
    parse_state_next     = parse_state;
    s1_next              = '0;
    if (good_rx) begin
      write_pointer_next = (write_pointer == LastIdx) ? '0 : write_pointer + 1'b1;
      if (byte_count == LastIdx) begin
        byte_count_next      = '0;
        overflow_sticky_next = 1'b1;
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
      s1_next.echo_valid = 1'b1;
      s1_next.echo_byte  = rx_byte;
      case (parse_state)
        PS_O: begin
          parse_state_next = (rx_byte == CH_K) ? PS_OK : PS_IDLE;
        end
        PS_OK: begin
          s1_next.ok_seen  = (rx_byte == CH_CR);
          parse_state_next = PS_IDLE;
        end
        PS_E: begin
          parse_state_next = (rx_byte == CH_G) ? PS_EG : PS_IDLE;
        end
        PS_EG: begin
          s1_next.light_update = (rx_byte == CH_1) || (rx_byte == CH_0);
          s1_next.light_on     = (rx_byte == CH_1);
          parse_state_next     = PS_IDLE;
        end
        default: begin
          if (rx_byte == CH_O) begin
            parse_state_next = PS_O;
          end else if (rx_byte == CH_E) begin
            parse_state_next = PS_E;
          end else begin
            parse_state_next = PS_IDLE;
          end
        end
      endcase
    end else if (do_read) begin
      read_pointer_next  = (read_pointer == LastIdx) ? '0 : read_pointer + 1'b1;
      byte_count_next    = byte_count - 1'b1;
      s1_next.read_valid = 1'b1;
    end
    count_ext             = {{FillW{1'b0}}, byte_count_next};
    s1_next.overflow_flag = overflow_sticky_next;
    s1_next.fill_count    = count_ext[FillW-1:0];
  end

  always_comb begin
    m_tdata_next        = '0;
    m_tdata_next[0]     = s1.read_valid;
    m_tdata_next[8:1]   = s1.read_valid ? ram_q : '0;
    m_tdata_next[9]     = s1.echo_valid;
    m_tdata_next[17:10] = s1.echo_byte;
    m_tdata_next[18]    = s1.ok_seen;
    m_tdata_next[19]    = s1.light_update;
    m_tdata_next[20]    = s1.light_on;
    m_tdata_next[21]    = s1.overflow_flag;
    m_tdata_next[24:22] = s1.fill_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer   <= '0;
      read_pointer    <= '0;
      byte_count      <= '0;
      overflow_sticky <= 1'b0;
      parse_state     <= PS_IDLE;
      s1_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      write_pointer   <= write_pointer_next;
      read_pointer    <= read_pointer_next;
      byte_count      <= byte_count_next;
      overflow_sticky <= overflow_sticky_next;
      parse_state     <= parse_state_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_move) begin
      m_tdata <= m_tdata_next;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("Accepted request did not reach the result stage.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1)))
    else $error("Stalled result stage changed.");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == ACT_READ) && (byte_count == '0)) |=> !s1.read_valid)
    else $error("Read on an empty buffer returned a byte.");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_sticky |=> overflow_sticky)
    else $error("Overflow flag cleared without reset.");

endmodule
